### rtl/core/bmp_stream_decoder_core_macros.svh
// Assertion macros for the BMP stream decoder core.
`ifndef BMP_STREAM_DECODER_CORE_MACROS_SVH
`define BMP_STREAM_DECODER_CORE_MACROS_SVH
`ifndef SYNTH
// Implication checked at every rising clock edge outside reset.
`define BSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define BSD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BSD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/core/bsd_pkg.sv
// Shared types and constants of the BMP stream decoder.
`timescale 1ns / 1ps
package bsd_pkg;
    localparam int WIDTH_CAP_DEF  = 1024;
    localparam int HEIGHT_CAP_DEF = 1024;

    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam logic [31:0] INFO_SIZE  = 32'd40;
    localparam logic [31:0] HDR_BYTES  = 32'd54;
    localparam logic [15:0] DEPTH_24   = 16'd24;
    localparam logic [15:0] DEPTH_32   = 16'd32;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

    localparam logic [2:0] ST_PIXEL     = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_BAD_INFO  = 3'd2;
    localparam logic [2:0] ST_COMPRESS  = 3'd3;
    localparam logic [2:0] ST_BAD_DIM   = 3'd4;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd5;
    localparam logic [2:0] ST_BAD_OFS   = 3'd6;
    localparam logic [2:0] ST_TRUNC     = 3'd7;

    localparam logic CFG_MAX_WIDTH  = 1'b0;
    localparam logic CFG_MAX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [10:0] img_width;
        logic [10:0] img_height;
        logic        is_last;
    } result_t;
endpackage

### rtl/core/bmp_stream_decoder_core.sv
// Top level of the BMP stream decoder: parser front, result queue, ports.
// BMP stream decoder. Bytes of a BMP file (BITMAPINFOHEADER, uncompressed,
// 24 or 32 bit) enter through a push/full queue port, one byte per transfer;
// first_byte restarts parsing and end_marker closes the stream. The front
// parses the 54 header bytes, checks them, skips to the pixel offset and
// assembles BGR/BGRA bytes into RGBA pixels with their top-down index.
// The front handles each byte as it is taken, so one transfer per clock is
// sustained; the only stall comes from the two-entry result queue filling
// when pop is held low. Errors give one result with a nonzero status and
// is_last set, after which bytes are dropped until the next first_byte.
// max_width/max_height (cfg index 0/1) are sampled when the header's
// dimension fields complete; write them only while the block is idle.
`timescale 1ns / 1ps
`include "bmp_stream_decoder_core_macros.svh"
module bmp_stream_decoder_core #(
    parameter int WIDTH_CAP  = bsd_pkg::WIDTH_CAP_DEF,
    parameter int HEIGHT_CAP = bsd_pkg::HEIGHT_CAP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        end_marker,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [19:0] pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [10:0] img_width,
    output logic [10:0] img_height,
    output logic        is_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);
    logic [10:0] max_width_reg, max_height_reg;
    logic        in_take, res_push;
    logic        err_out;
    bsd_pkg::result_t res_data, out_data;

    assign cfg_ready = 1'b1;
    assign in_take   = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_width_reg  <= 11'd640;
            max_height_reg <= 11'd480;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == bsd_pkg::CFG_MAX_WIDTH) max_width_reg <= cfg_data;
            else max_height_reg <= cfg_data;
        end
    end

    bsd_front #(
        .WIDTH_CAP  (WIDTH_CAP),
        .HEIGHT_CAP (HEIGHT_CAP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_take    (in_take),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .end_marker (end_marker),
        .max_width  (max_width_reg),
        .max_height (max_height_reg),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    // push only on accepted bytes; a full queue already blocks input
    bsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push && in_take),
        .wr_data (res_data),
        .pop     (pop),
        .full    (full),
        .empty   (empty),
        .rd_data (out_data)
    );

    assign status       = out_data.status;
    assign pixel_index  = out_data.pixel_index;
    assign red          = out_data.red;
    assign green        = out_data.green;
    assign blue         = out_data.blue;
    assign alpha        = out_data.alpha;
    assign img_width    = out_data.img_width;
    assign img_height   = out_data.img_height;
    assign is_last      = out_data.is_last;

    // an error result is waiting at the output
    assign err_out = !empty && status != bsd_pkg::ST_PIXEL;

    `BSD_NEVER(a_full_empty, clk, rst_n, full && empty, "queue full and empty")
    `BSD_ASSERT(a_err_last, clk, rst_n, err_out |-> is_last, "error without is_last")
    `BSD_ASSERT(a_err_zero, clk, rst_n, err_out |-> (pixel_index == 20'd0 && img_width == 11'd0), "error payload")
endmodule

### rtl/core/bsd_front.sv
// Byte parser: header gathering and checks, skip, pixel assembly.
`timescale 1ns / 1ps
module bsd_front #(
    parameter int WIDTH_CAP  = bsd_pkg::WIDTH_CAP_DEF,
    parameter int HEIGHT_CAP = bsd_pkg::HEIGHT_CAP_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  logic [7:0]        data_byte,
    input  logic              first_byte,
    input  logic              end_marker,
    input  logic [10:0]       max_width,
    input  logic [10:0]       max_height,
    output logic              res_push,
    output bsd_pkg::result_t  res_data
);
    typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXEL, PH_DONE} phase_t;

    localparam logic [31:0] WCAP = 32'(WIDTH_CAP);
    localparam logic [31:0] HCAP = 32'(HEIGHT_CAP);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] offset_reg, offset_next;
    logic [2:0]  fault_reg, fault_next;
    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic        td_reg, td_next;
    logic        bpp4_reg, bpp4_next;
    logic [10:0] rows_reg, rows_next;
    logic [12:0] bir_reg, bir_next;
    logic [1:0]  bip_reg, bip_next;
    logic [23:0] held_reg, held_next;
    logic [19:0] idx_reg, idx_next;
    logic [19:0] rstart_reg, rstart_next;
    logic [19:0] prod_reg;
    logic [12:0] data_bytes_reg, row_bytes_reg;

    phase_t      ph_e;
    logic [31:0] pos_e, gather_e, habs, wlim, hlim;
    logic [2:0]  fault_a;
    logic [12:0] data_bytes_c;
    logic [10:0] hm1;
    logic [21:0] prod_full;

    function automatic logic [2:0] note(input logic [2:0] f, input logic [2:0] c);
        note = (f == 3'd0 || c < f) ? c : f;
    endfunction

    assign wlim = (32'(max_width) < WCAP) ? 32'(max_width) : WCAP;
    assign hlim = (32'(max_height) < HCAP) ? 32'(max_height) : HCAP;
    assign data_bytes_c = bpp4_reg ? {width_reg, 2'b00}
                                   : (13'(width_reg) + {1'b0, width_reg, 1'b0});
    assign hm1 = height_reg - 11'd1;
    assign prod_full = hm1 * width_reg;

    always_comb
    begin
        ph_e     = first_byte ? PH_HEADER : phase_reg;
        pos_e    = first_byte ? 32'd0 : pos_reg;
        gather_e = first_byte ? 32'd0 : gather_reg;
        fault_a  = first_byte ? 3'd0 : fault_reg;
        phase_next = ph_e;       pos_next = pos_e;
        gather_next = gather_e;  offset_next = offset_reg;
        fault_next = fault_a;    width_next = width_reg;
        height_next = height_reg; td_next = td_reg;
        bpp4_next = bpp4_reg;    rows_next = rows_reg;
        bir_next = bir_reg;      bip_next = bip_reg;
        held_next = held_reg;    idx_next = idx_reg;
        rstart_next = rstart_reg;
        habs = 32'd0;
        res_push = 1'b0;
        res_data = '0;
        res_data.is_last = 1'b1;
        if (end_marker) begin
            if (ph_e != PH_DONE) begin
                res_push = 1'b1;
                res_data.status = bsd_pkg::ST_TRUNC;
                phase_next = PH_DONE;
            end
        end else begin
            unique case (ph_e)
                PH_HEADER:
                begin
                    gather_next = {data_byte, gather_e[31:8]};
                    pos_next = pos_e + 32'd1;
                    if ((pos_e == 32'd0 && data_byte != bsd_pkg::SIG_B) ||
                        (pos_e == 32'd1 && data_byte != bsd_pkg::SIG_M))
                        fault_next = note(fault_a, bsd_pkg::ST_BAD_SIG);
                    case (pos_e)
                        32'd13:
                        begin
                            offset_next = gather_next;
                            if (fault_next == bsd_pkg::ST_BAD_SIG) begin
                                res_push = 1'b1;
                                res_data.status = bsd_pkg::ST_BAD_SIG;
                                phase_next = PH_DONE;
                            end
                        end
                        32'd17:
                            if (gather_next != bsd_pkg::INFO_SIZE)
                                fault_next = note(fault_a, bsd_pkg::ST_BAD_INFO);
                        32'd21:
                        begin
                            width_next = gather_next[10:0];
                            if (gather_next[31] || gather_next == 32'd0 || gather_next > wlim)
                                fault_next = note(fault_a, bsd_pkg::ST_BAD_DIM);
                        end
                        32'd25:
                        begin
                            td_next = gather_next[31];
                            habs = gather_next[31] ? (32'd0 - gather_next) : gather_next;
                            height_next = habs[10:0];
                            if (habs == 32'd0 || habs > hlim)
                                fault_next = note(fault_a, bsd_pkg::ST_BAD_DIM);
                        end
                        32'd29:
                            if (gather_next[31:16] == bsd_pkg::DEPTH_24) bpp4_next = 1'b0;
                            else if (gather_next[31:16] == bsd_pkg::DEPTH_32) bpp4_next = 1'b1;
                            else fault_next = note(fault_a, bsd_pkg::ST_BAD_DEPTH);
                        32'd33:
                            if (gather_next != 32'd0)
                                fault_next = note(fault_a, bsd_pkg::ST_COMPRESS);
                        32'd53:
                        begin
                            if (fault_a != 3'd0) begin
                                res_push = 1'b1;
                                res_data.status = fault_a;
                                phase_next = PH_DONE;
                            end else if (offset_reg < bsd_pkg::HDR_BYTES) begin
                                res_push = 1'b1;
                                res_data.status = bsd_pkg::ST_BAD_OFS;
                                phase_next = PH_DONE;
                            end else if (offset_reg == bsd_pkg::HDR_BYTES) begin
                                phase_next = PH_PIXEL;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                        default: ;
                    endcase
                    if (pos_e == 32'd53 && phase_next == PH_PIXEL) begin
                        rows_next = '0; bir_next = '0; bip_next = '0; held_next = '0;
                        idx_next = td_reg ? 20'd0 : prod_reg;
                        rstart_next = prod_reg;
                    end
                end
                PH_SKIP:
                begin
                    pos_next = pos_e + 32'd1;
                    if (pos_next == offset_reg) begin
                        phase_next = PH_PIXEL;
                        rows_next = '0; bir_next = '0; bip_next = '0; held_next = '0;
                        idx_next = td_reg ? 20'd0 : prod_reg;
                        rstart_next = prod_reg;
                    end
                end
                PH_PIXEL:
                begin
                    bir_next = bir_reg + 13'd1;
                    if (bir_reg < data_bytes_reg) begin
                        if (bip_reg != 2'd3)
                            held_next = held_reg | (24'(data_byte) << {bip_reg, 3'b000});
                        if ((bip_reg == 2'd2 && !bpp4_reg) || bip_reg == 2'd3) begin
                            res_push = 1'b1;
                            res_data.status = bsd_pkg::ST_PIXEL;
                            res_data.pixel_index = idx_reg;
                            res_data.red   = held_next[23:16];
                            res_data.green = held_next[15:8];
                            res_data.blue  = held_next[7:0];
                            res_data.alpha = bpp4_reg ? data_byte : bsd_pkg::ALPHA_OPAQUE;
                            res_data.img_width  = width_reg;
                            res_data.img_height = height_reg;
                            res_data.is_last = (12'(rows_reg) + 12'd1 == 12'(height_reg)) &&
                                               (bir_next == data_bytes_reg);
                            idx_next = idx_reg + 20'd1;
                            bip_next = 2'd0;
                            held_next = '0;
                        end else begin
                            bip_next = bip_reg + 2'd1;
                        end
                    end
                    if (res_push && res_data.is_last) begin
                        phase_next = PH_DONE;
                    end else if (bir_next >= row_bytes_reg) begin
                        bir_next = '0;
                        rows_next = rows_reg + 11'd1;
                        // bottom-up rows step back one width; top-down just continue
                        if (!td_reg) begin
                            rstart_next = rstart_reg - 20'(width_reg);
                            idx_next = rstart_next;
                        end
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            gather_reg <= '0;
            fault_reg <= '0;
        end else if (in_take) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            gather_reg <= gather_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_full[19:0];
        data_bytes_reg <= data_bytes_c;
        row_bytes_reg  <= (data_bytes_c + 13'd3) & ~13'd3;
        if (in_take) begin
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            td_reg     <= td_next;
            bpp4_reg   <= bpp4_next;
            rows_reg   <= rows_next;
            bir_reg    <= bir_next;
            bip_reg    <= bip_next;
            held_reg   <= held_next;
            idx_reg    <= idx_next;
            rstart_reg <= rstart_next;
        end
    end
endmodule

### rtl/core/bsd_queue.sv
// Two-entry result queue between the parser and the output ports.
`timescale 1ns / 1ps
module bsd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bsd_pkg::result_t  wr_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output bsd_pkg::result_t  rd_data
);
    bsd_pkg::result_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) wp_reg <= ~wp_reg;
            if (do_pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wp_reg] <= wr_data;
    end
endmodule
